@@ rtl/core/ttg_pkg.sv @@
package ttg_pkg;

	localparam int IDX_W  = 16;
	localparam int POS_W  = 32;
	localparam int TEX_W  = 24;
	localparam int TAN_W  = 16;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// one input transaction
	typedef struct packed {
		logic                    mesh_start;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [TEX_W-1:0] tex_s;
		logic signed [TEX_W-1:0] tex_t;
	} vtx_in_t;

	// one result transaction
	typedef struct packed {
		logic signed [TAN_W-1:0] tangent_x;
		logic signed [TAN_W-1:0] tangent_y;
		logic signed [TAN_W-1:0] tangent_z;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
		logic                    degenerate;
	} res_out_t;

	// geometry of one triangle corner
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic signed [TEX_W-1:0] s;
		logic signed [TEX_W-1:0] t;
	} corner_t;

	// engine result
	typedef struct packed {
		logic signed [TAN_W-1:0] x;
		logic signed [TAN_W-1:0] y;
		logic signed [TAN_W-1:0] z;
		logic                    degenerate;
	} tangent_t;

endpackage

@@ rtl/core/ttg_mul.sv @@
module ttg_mul (
	input  logic                             clk,
	input  logic signed [ttg_pkg::MUL_W-1:0] a,
	input  logic signed [ttg_pkg::MUL_W-1:0] b,
	output logic signed [ttg_pkg::PROD_W-1:0] prod
);
	import ttg_pkg::*;

	// registered signed product
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

@@ rtl/core/ttg_engine.sv @@
module ttg_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ttg_pkg::corner_t   ca,
	input  ttg_pkg::corner_t   cb,
	input  ttg_pkg::corner_t   cc,
	input  logic               take,
	output logic               busy,
	output logic               done,
	output ttg_pkg::tangent_t  tan
);
	import ttg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_MAG, S_NORM, S_SQRT, S_DIVI, S_DIV, S_DONE
	} state_t;

	state_t                     state_q;
	logic [3:0]                 op_q;
	logic [4:0]                 cnt_q;
	logic [1:0]                 comp_q;
	logic signed [TEX_W:0]      ds1_q, dt1_q, ds2_q, dt2_q;
	logic signed [POS_W:0]      dp1_q [0:2];
	logic signed [POS_W:0]      dp2_q [0:2];
	logic signed [58:0]         acc_q;
	logic signed [58:0]         res_q [0:3];
	logic [58:0]                mag_q [0:2];
	logic [2:0]                 neg_q;
	logic [61:0]                len2_q;
	logic [63:0]                x_q, r_q, bit_q;
	logic [30:0]                len_q;
	logic [30:0]                rem_q;
	logic [14:0]                numlo_q;
	logic [13:0]                quo_q;
	tangent_t                   tan_q;

	logic signed [MUL_W-1:0]    opa, opb;
	logic signed [PROD_W-1:0]   prod;
	logic signed [58:0]         diff;
	logic [58:0]                mag_or;
	logic [63:0]                sq_sum;
	logic [63:0]                r_nxt;
	logic [44:0]                num;
	logic [31:0]                div_t;
	logic                       qbit;
	logic [14:0]                qn;
	logic signed [TAN_W-1:0]    qs;
	logic [1:0]                 k_v;

	ttg_mul u_mul (.clk(clk), .a(opa), .b(opb), .prod(prod));

	// operand selection for the shared multiplier
	always_comb begin
		k_v = op_q[2:1] - 2'd1;
		opa = '0;
		opb = '0;
		if (op_q >= 4'd8) begin
			opa = {3'b0, mag_q[op_q[1:0]][29:0]};
			opb = {3'b0, mag_q[op_q[1:0]][29:0]};
		end else if (op_q < 4'd2) begin
			opa = op_q[0] ? {{8{dt1_q[TEX_W]}}, dt1_q} : {{8{ds1_q[TEX_W]}}, ds1_q};
			opb = op_q[0] ? {{8{ds2_q[TEX_W]}}, ds2_q} : {{8{dt2_q[TEX_W]}}, dt2_q};
		end else begin
			opa = op_q[0] ? dp2_q[k_v] : dp1_q[k_v];
			opb = op_q[0] ? {{8{dt1_q[TEX_W]}}, dt1_q} : {{8{dt2_q[TEX_W]}}, dt2_q};
		end
	end

	always_comb begin
		diff   = acc_q - prod[58:0];
		mag_or = mag_q[0] | mag_q[1] | mag_q[2];
		sq_sum = r_q + bit_q;
		r_nxt  = (x_q >= sq_sum) ? (r_q >> 1) + bit_q : r_q >> 1;
		num    = {1'b0, mag_q[comp_q][29:0], 14'b0} + {15'b0, len_q[30:1]};
		div_t  = {rem_q, numlo_q[14]};
		qbit   = div_t >= {1'b0, len_q};
		qn     = {quo_q, qbit};
		qs     = neg_q[comp_q] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ds1_q <= {cb.s[TEX_W-1], cb.s} - {ca.s[TEX_W-1], ca.s};
						dt1_q <= {cb.t[TEX_W-1], cb.t} - {ca.t[TEX_W-1], ca.t};
						ds2_q <= {cc.s[TEX_W-1], cc.s} - {ca.s[TEX_W-1], ca.s};
						dt2_q <= {cc.t[TEX_W-1], cc.t} - {ca.t[TEX_W-1], ca.t};
						dp1_q[0] <= {cb.x[POS_W-1], cb.x} - {ca.x[POS_W-1], ca.x};
						dp1_q[1] <= {cb.y[POS_W-1], cb.y} - {ca.y[POS_W-1], ca.y};
						dp1_q[2] <= {cb.z[POS_W-1], cb.z} - {ca.z[POS_W-1], ca.z};
						dp2_q[0] <= {cc.x[POS_W-1], cc.x} - {ca.x[POS_W-1], ca.x};
						dp2_q[1] <= {cc.y[POS_W-1], cc.y} - {ca.y[POS_W-1], ca.y};
						dp2_q[2] <= {cc.z[POS_W-1], cc.z} - {ca.z[POS_W-1], ca.z};
						op_q    <= '0;
						tan_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					op_q    <= op_q + 4'd1;
					state_q <= S_MUL;
					if (op_q >= 4'd8) begin
						len2_q <= (op_q == 4'd8 ? 62'd0 : len2_q) + prod[61:0];
						if (op_q == 4'd10) begin
							x_q     <= {2'b0, len2_q + prod[61:0]};
							r_q     <= '0;
							bit_q   <= 64'd1 << 62;
							cnt_q   <= '0;
							state_q <= S_SQRT;
						end
					end else if (!op_q[0]) begin
						acc_q <= prod[58:0];
					end else begin
						res_q[op_q[2:1]] <= diff;
						if (op_q == 4'd1 && diff == '0) begin
							tan_q.degenerate <= 1'b1;
							state_q <= S_DONE;
						end else if (op_q == 4'd7) begin
							state_q <= S_MAG;
						end
					end
				end
				S_MAG: begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= res_q[k+1][58] ? 59'(-res_q[k+1]) : 59'(res_q[k+1]);
						neg_q[k] <= res_q[k+1][58] ^ res_q[0][58];
					end
					state_q <= S_NORM;
				end
				S_NORM: begin
					// one bit a cycle until the largest lies in [2^29, 2^30)
					if (mag_or == '0) begin
						tan_q.degenerate <= 1'b1;
						state_q <= S_DONE;
					end else if (mag_or[58:30] != '0) begin
						for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
					end else if (!mag_or[29]) begin
						for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
					end else begin
						op_q    <= 4'd8;
						state_q <= S_MUL;
					end
				end
				S_SQRT: begin
					if (x_q >= sq_sum) begin
						x_q <= x_q - sq_sum;
					end
					r_q   <= r_nxt;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						// the final root is the length for all three divisions
						len_q   <= r_nxt[30:0];
						comp_q  <= '0;
						state_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					rem_q   <= {1'b0, num[44:15]};
					numlo_q <= num[14:0];
					cnt_q   <= '0;
					quo_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q   <= qbit ? 31'(div_t - {1'b0, len_q}) : div_t[30:0];
					numlo_q <= numlo_q << 1;
					quo_q   <= qn[13:0];
					cnt_q   <= cnt_q + 5'd1;
					if (cnt_q == 5'd14) begin
						case (comp_q)
							2'd0:    tan_q.x <= qs;
							2'd1:    tan_q.y <= qs;
							default: tan_q.z <= qs;
						endcase
						comp_q  <= comp_q + 2'd1;
						state_q <= (comp_q == 2'd2) ? S_DONE : S_DIVI;
					end
				end
				S_DONE: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
	assign tan  = tan_q;

endmodule

@@ rtl/core/triangle_tangent_generator.sv @@
// channel | direction | handshake             | payload
// in      | to block  | in_valid / in_stall   | in_data (vtx_in_t), one vertex
// out     | from block| out_valid / out_stall | out_data (res_out_t), one tangent
// cfg     | to block  | cfg_wr_en             | cfg_wr_data (strip_mode)
// a vertex that only fills the window is stored without starting the engine; a
// zero determinant ends after the first two products; otherwise the products on
// the shared multiplier, normalising shifts, square root and division run in turn
// in_stall is high while the engine holds a triangle; out_stall only holds the
// engine once the output register is full; reset empties the window and strip_mode
module triangle_tangent_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ttg_pkg::vtx_in_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ttg_pkg::res_out_t  out_data,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data
);
	import ttg_pkg::*;

	logic             strip_q;
	logic [1:0]       fill_q;
	logic [IDX_W-1:0] win_idx_q [0:1];
	corner_t          win_q [0:1];
	logic [IDX_W-1:0] corner_a_q, corner_b_q, corner_c_q;
	corner_t          ca_q, cb_q, cc_q;
	logic             out_valid_q;
	res_out_t         out_data_q;

	logic             accept, start, take;
	logic [1:0]       fill_eff;
	corner_t          cur;
	logic             eng_busy, eng_busy_raw, eng_done;
	tangent_t         eng_tan;

	// current vertex geometry
	assign cur = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z,
		s: in_data.tex_s, t: in_data.tex_t};

	assign in_stall = eng_busy;
	assign accept   = in_valid && !in_stall;
	// a new mesh empties the window before this vertex lands
	assign fill_eff = in_data.mesh_start ? 2'd0 : fill_q;
	assign start    = accept && (fill_eff == 2'd2);
	// move a finished tangent into the output register when it has room
	assign take     = eng_done && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q     <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) strip_q <= cfg_wr_data;
			if (accept) begin
				if (fill_eff != 2'd2) begin
					fill_q <= fill_eff + 2'd1;
				end else if (!strip_q) begin
					// list mode: window empties after each triangle
					fill_q <= '0;
				end
			end
			if (take) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	// window and triangle payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (fill_eff != 2'd2) begin
				win_idx_q[fill_eff[0]] <= in_data.vertex_index;
				win_q[fill_eff[0]]     <= cur;
			end else begin
				ca_q       <= win_q[0];
				cb_q       <= win_q[1];
				cc_q       <= cur;
				corner_a_q <= win_idx_q[0];
				corner_b_q <= win_idx_q[1];
				corner_c_q <= in_data.vertex_index;
				if (strip_q) begin
					// strip mode: slide by one vertex
					win_idx_q[0] <= win_idx_q[1];
					win_q[0]     <= win_q[1];
					win_idx_q[1] <= in_data.vertex_index;
					win_q[1]     <= cur;
				end
			end
		end
		if (take) begin
			out_data_q.tangent_x  <= eng_tan.x;
			out_data_q.tangent_y  <= eng_tan.y;
			out_data_q.tangent_z  <= eng_tan.z;
			out_data_q.degenerate <= eng_tan.degenerate;
			out_data_q.corner_a   <= corner_a_q;
			out_data_q.corner_b   <= corner_b_q;
			out_data_q.corner_c   <= corner_c_q;
		end
	end

	// engine starts in the cycle after the corners are latched
	logic start_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 1'b0;
		else start_q <= start;
	end

	ttg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.ca     (ca_q),
		.cb     (cb_q),
		.cc     (cc_q),
		.take   (take),
		.busy   (eng_busy_raw),
		.done   (eng_done),
		.tan    (eng_tan)
	);

	// hold the input off across the latch cycle too
	assign eng_busy = eng_busy_raw || start_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ verif/triangle_tangent_generator_tb.sv @@
module triangle_tangent_generator_tb;
	import ttg_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;
	localparam int RANDOM_VERTICES = 1450;
	localparam int DRAIN_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	vtx_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	res_out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	triangle_tangent_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of the vertex window and the mode register
	typedef struct {
		logic [IDX_W-1:0] idx;
		longint p[3];
		longint tx[2];
	} corner_rec_t;

	corner_rec_t win[2];
	int unsigned win_fill = 0;
	bit strip = 1'b0;

	res_out_t tangent_queue[$];
	int error_count = 0;
	int unsigned cycle_count = 0;
	bit hold_receiver = 1'b0;
	bit pause_receiver = 1'b0;

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// exact edges weighted by uv deltas, then fixed-point normalisation
	function automatic res_out_t triangle_tangent(corner_rec_t a, corner_rec_t b,
			corner_rec_t c);
		res_out_t r;
		longint ds1, dt1, ds2, dt2, det, v;
		longint unsigned mag[3];
		longint unsigned m, len2, len, q;
		bit neg[3];
		r = '0;
		r.corner_a = a.idx;
		r.corner_b = b.idx;
		r.corner_c = c.idx;
		r.degenerate = 1'b1;
		ds1 = b.tx[0] - a.tx[0];
		dt1 = b.tx[1] - a.tx[1];
		ds2 = c.tx[0] - a.tx[0];
		dt2 = c.tx[1] - a.tx[1];
		det = ds1 * dt2 - dt1 * ds2;
		if (det == 0) return r;
		m = 0;
		for (int k = 0; k < 3; k++) begin
			v = (b.p[k] - a.p[k]) * dt2 - (c.p[k] - a.p[k]) * dt1;
			if (det < 0) v = -v;
			neg[k] = v < 0;
			mag[k] = neg[k] ? longint'(-v) : longint'(v);
			if (mag[k] > m) m = mag[k];
		end
		if (m == 0) return r;
		while (m >= (64'd1 << 30)) begin
			for (int k = 0; k < 3; k++) mag[k] >>= 1;
			m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			for (int k = 0; k < 3; k++) mag[k] <<= 1;
			m <<= 1;
		end
		len2 = 0;
		for (int k = 0; k < 3; k++) len2 += mag[k] * mag[k];
		len = root_floor(len2);
		for (int k = 0; k < 3; k++) begin
			q = (mag[k] * 64'd16384 + len / 2) / len;
			if (neg[k]) q = -q;
			if (k == 0) r.tangent_x = q[15:0];
			if (k == 1) r.tangent_y = q[15:0];
			if (k == 2) r.tangent_z = q[15:0];
		end
		r.degenerate = 1'b0;
		return r;
	endfunction

	// returns 1 and the tangent when this vertex completes a triangle
	function automatic bit window_step(vtx_in_t d, output res_out_t res);
		corner_rec_t cur;
		res = '0;
		if (d.mesh_start) win_fill = 0;
		cur.idx = d.vertex_index;
		cur.p[0] = d.pos_x;
		cur.p[1] = d.pos_y;
		cur.p[2] = d.pos_z;
		cur.tx[0] = d.tex_s;
		cur.tx[1] = d.tex_t;
		if (win_fill < 2) begin
			win[win_fill] = cur;
			win_fill++;
			return 1'b0;
		end
		res = triangle_tangent(win[0], win[1], cur);
		if (strip) begin
			win[0] = win[1];
			win[1] = cur;
		end else begin
			win_fill = 0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		error_count++;
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result checker, compares each transaction with the oldest expectation
	always @(posedge clk) begin
		res_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tangent_queue.size() == 0) begin
				report_mismatch("unexpected transaction, corner_c", out_data.corner_c, -1);
			end else begin
				want = tangent_queue.pop_front();
				if (out_data.tangent_x !== want.tangent_x)
					report_mismatch("tangent_x", out_data.tangent_x, want.tangent_x);
				if (out_data.tangent_y !== want.tangent_y)
					report_mismatch("tangent_y", out_data.tangent_y, want.tangent_y);
				if (out_data.tangent_z !== want.tangent_z)
					report_mismatch("tangent_z", out_data.tangent_z, want.tangent_z);
				if (out_data.corner_a !== want.corner_a)
					report_mismatch("corner_a", out_data.corner_a, want.corner_a);
				if (out_data.corner_b !== want.corner_b)
					report_mismatch("corner_b", out_data.corner_b, want.corner_b);
				if (out_data.corner_c !== want.corner_c)
					report_mismatch("corner_c", out_data.corner_c, want.corner_c);
				if (out_data.degenerate !== want.degenerate)
					report_mismatch("degenerate", out_data.degenerate, want.degenerate);
			end
		end
	end

	// receiver stall: random gaps, occasionally a long forced hold-off
	always @(posedge clk) begin
		int unsigned hold_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else if (hold_receiver && hold_left == 0 && !pause_receiver) begin
			pause_receiver = 1'b1;
			hold_left = 1500;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= hold_left != 0;
		end else if ($urandom_range(0, 3) == 0) begin
			hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300)
				: $urandom_range(1, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// random content helpers
	function automatic logic signed [POS_W-1:0] random_pos(int shape);
		case (shape)
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [TEX_W-1:0] random_tex(int shape);
		case (shape)
			0: return 24'sh80_0000;
			1: return 24'sh7F_FFFF;
			2: return 24'($signed($urandom_range(0, 60)) - 30);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic vtx_in_t random_vertex(bit start, int unsigned idx);
		vtx_in_t v;
		int shape;
		shape = $urandom_range(0, 9);
		shape = shape < 1 ? 0 : shape < 2 ? 1 : shape < 4 ? 2 : 3;
		v.mesh_start = start;
		v.vertex_index = 16'(idx);
		v.pos_x = random_pos(shape);
		v.pos_y = random_pos($urandom_range(0, 3));
		v.pos_z = random_pos(shape);
		v.tex_s = random_tex($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : shape);
		v.tex_t = random_tex($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : shape);
		return v;
	endfunction

	// offer one vertex and wait for it to be taken; update the prediction on acceptance
	task automatic send_vertex(vtx_in_t v, bit has_fixed, res_out_t fixed_res);
		res_out_t res;
		in_data <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (window_step(v, res)) begin
			if (has_fixed && fixed_res !== res)
				report_mismatch("predictor versus table, corner_c", res.corner_c,
					fixed_res.corner_c);
			tangent_queue.push_back(res);
		end
		if ($urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 24) == 0) ? $urandom_range(30, 200)
				: $urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tangent_queue.size() != 0) @(posedge clk);
		// a vertex that only fills the window needs no further time, but a margin is cheap
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(bit mode);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		strip = mode;
	endtask

	// directed stimulus table
	typedef struct {
		vtx_in_t v;
		bit has_fixed;
		res_out_t fixed_res;
	} stim_row_t;

	function automatic vtx_in_t mk(bit st, int idx, int px, int py, int pz, int s, int t);
		vtx_in_t v;
		v.mesh_start = st;
		v.vertex_index = 16'(idx);
		v.pos_x = px;
		v.pos_y = py;
		v.pos_z = pz;
		v.tex_s = 24'(s);
		v.tex_t = 24'(t);
		return v;
	endfunction

	function automatic res_out_t deg_res(int a, int b, int c);
		res_out_t r;
		r = '0;
		r.corner_a = 16'(a);
		r.corner_b = 16'(b);
		r.corner_c = 16'(c);
		r.degenerate = 1'b1;
		return r;
	endfunction

	initial begin
		stim_row_t rows[$];
		res_out_t none;
		bit m;
		int unsigned idx;
		none = '0;
		// list mode after reset: unit triangle, tangent along +x
		rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0), 0, none});
		rows.push_back('{mk(0, 1, 65536, 0, 0, 65536, 0), 0, none});
		rows.push_back('{mk(0, 2, 0, 65536, 0, 0, 65536), 1,
			'{16'sd16384, 16'sd0, 16'sd0, 16'd0, 16'd1, 16'd2, 1'b0}});
		// zero determinant, all uvs equal
		rows.push_back('{mk(0, 3, 5, 6, 7, 9, 9), 0, none});
		rows.push_back('{mk(0, 4, 100, -6, 7, 9, 9), 0, none});
		rows.push_back('{mk(0, 65535, 8, 60, -7, 9, 9), 1, deg_res(3, 4, 65535)});
		// zero tangent: positions all equal, uvs fine
		rows.push_back('{mk(0, 7, 42, 42, 42, 0, 0), 0, none});
		rows.push_back('{mk(0, 8, 42, 42, 42, 65536, 0), 0, none});
		rows.push_back('{mk(0, 9, 42, 42, 42, 0, 65536), 1, deg_res(7, 8, 9)});
		// mesh start after a partial window drops the old vertex
		rows.push_back('{mk(0, 10, 1, 2, 3, 4, 5), 0, none});
		rows.push_back('{mk(1, 11, 0, 0, 0, 0, 0), 0, none});
		rows.push_back('{mk(0, 12, 0, 0, 65536, 0, 65536), 0, none});
		rows.push_back('{mk(0, 13, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			24'h80_0000, 24'h7F_FFFF), 0, none});
		// extremes of every field
		rows.push_back('{mk(1, 65535, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			24'h7F_FFFF, 24'h80_0000), 0, none});
		rows.push_back('{mk(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			24'h80_0000, 24'h7F_FFFF), 0, none});
		rows.push_back('{mk(0, 21845, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			24'h80_0000, 24'h80_0000), 0, none});
		// leave two in the window for the mode switch
		rows.push_back('{mk(0, 30, 3, -3, 1000, 70, -70), 0, none});
		rows.push_back('{mk(0, 31, -3000, 300, 7, -700, 7), 0, none});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_vertex(rows[i].v, rows[i].has_fixed, rows[i].fixed_res);
		wait_idle();

		// mode switch mid-stream keeps the window; strip then slides
		write_mode(1'b1);
		for (int i = 0; i < 5; i++)
			send_vertex(mk(0, 40 + i, i * 7000 - 9, i * i * 300, -i, i * 500, i * i * 90),
				0, none);
		wait_idle();
		// back to list with a full window: one triangle, then empty
		write_mode(1'b0);
		send_vertex(mk(0, 50, 77, 88, 99, 1234, -4321), 0, none);
		send_vertex(mk(0, 51, 1, 88, 99, 34, -21), 0, none);
		wait_idle();

		// random phases alternating the mode
		idx = 0;
		for (int ph = 0; ph < 6; ph++) begin
			m = ph[0];
			write_mode(m);
			for (int i = 0; i < RANDOM_VERTICES / 6; i++) begin
				if (ph == 2 && i == 20) hold_receiver = 1'b1;
				if (ph == 2 && i == 40) hold_receiver = 1'b0;
				if (ph == 4 && i == 100) begin
					// sender waits until every expected tangent is back
					in_valid <= 1'b0;
					while (tangent_queue.size() != 0) @(posedge clk);
				end
				idx = ($urandom_range(0, 30) == 0) ? $urandom : idx + 1;
				send_vertex(random_vertex($urandom_range(0, 40) == 0, idx), 0, none);
			end
			wait_idle();
		end

		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/ttg_pkg.sv
rtl/core/ttg_mul.sv
rtl/core/ttg_engine.sv
rtl/core/triangle_tangent_generator.sv
verif/triangle_tangent_generator_tb.sv
